// ===== rtl/core/blp_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, command codes and helpers for the binary trie lpm block
package blp_pkg;

  localparam int NODES_DEF  = 4096;
  localparam int ROUTES_DEF = 65536;
  localparam int ADDR_BITS  = 32;
  localparam int RID_W      = 16;
  localparam int LV_W       = $clog2(ADDR_BITS + 1);

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef logic [LV_W-1:0] lv_t;

  function automatic lv_t nibble_ones(input logic [3:0] n);
    lv_t c;
    c = lv_t'(n[0]) + lv_t'(n[1]) + lv_t'(n[2]) + lv_t'(n[3]);
    return c;
  endfunction

  // prefix length: per-nibble counts summed
  function automatic lv_t prefix_len(input logic [ADDR_BITS-1:0] m);
    lv_t s;
    s = '0;
    for (int i = 0; i < ADDR_BITS / 4; i++) begin
      s = s + nibble_ones(m[4*i +: 4]);
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/blp_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual port ram with registered read
module blp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/binary_trie_lpm.sv =====
`timescale 1ns / 1ps
// binary trie longest prefix match table for ipv4, top level
// lookup: walks from the root until a missing child or the last level, then reports the best match
// insert: walks the existing path, then chains new nodes down to the prefix end; one node memory access per level
// one command at a time, start is taken again in the cycle of out_valid
// reset: root emptied, free counter set to 1; other nodes are written on allocation
// results cannot be stalled: out_valid marks a one cycle beat
module binary_trie_lpm #(
  parameter int NODES  = blp_pkg::NODES_DEF,
  parameter int ROUTES = blp_pkg::ROUTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic [blp_pkg::ADDR_BITS-1:0] in_address,
  input  logic [blp_pkg::ADDR_BITS-1:0] in_mask,
  input  logic [blp_pkg::RID_W-1:0]     in_route_id,
  output logic                         out_valid,
  output logic                         out_found,
  output logic [blp_pkg::RID_W-1:0]     out_match_id,
  output logic                         out_pool_full
);

  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = NODE_W + 1;
  localparam int RID_W  = blp_pkg::RID_W;
  localparam int AB     = blp_pkg::ADDR_BITS;
  localparam int LV_W   = blp_pkg::LV_W;
  localparam int WORD_W = 2 * NODE_W + 1 + RID_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              ins_r, ins_nxt;
  logic              bad_rid_r, bad_rid_nxt;
  logic [AB-1:0]     addr_sh_r, addr_sh_nxt;
  blp_pkg::lv_t      len_r, len_nxt;
  blp_pkg::lv_t      lv_r, lv_nxt;
  logic [RID_W-1:0]  rid_r, rid_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic              at_root_r, at_root_nxt;
  logic              got_r, got_nxt;
  logic [RID_W-1:0]  best_r, best_nxt;
  logic [CNT_W-1:0]  next_free_r, next_free_nxt;
  logic [NODE_W-1:0] root_l0_r, root_l0_nxt;
  logic [NODE_W-1:0] root_l1_r, root_l1_nxt;
  logic              root_has_r, root_has_nxt;
  logic [RID_W-1:0]  root_rid_r, root_rid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [RID_W-1:0]  out_match_id_r, out_match_id_nxt;
  logic              out_pool_full_r, out_pool_full_nxt;

  logic              ram_we;
  logic [NODE_W-1:0] ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [NODE_W-1:0] ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;

  logic [WORD_W-1:0] cur_word;
  logic [NODE_W-1:0] cur_l0, cur_l1, child, new_node, node_inc;
  logic              cur_has, bit_now, got_now;
  logic [RID_W-1:0]  cur_rid, best_now;
  logic [CNT_W-1:0]  free_left;
  blp_pkg::lv_t      missing, lv_inc;

  blp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign cur_word  = at_root_r ? {root_l0_r, root_l1_r, root_has_r, root_rid_r} : ram_rd_data;
  assign cur_l0    = cur_word[WORD_W-1 -: NODE_W];
  assign cur_l1    = cur_word[RID_W+1 +: NODE_W];
  assign cur_has   = cur_word[RID_W];
  assign cur_rid   = cur_word[RID_W-1:0];
  assign bit_now   = addr_sh_r[AB-1];
  assign child     = bit_now ? cur_l1 : cur_l0;
  assign got_now   = got_r | cur_has;
  assign best_now  = cur_has ? cur_rid : best_r;
  assign free_left = CNT_W'(NODES) - next_free_r;
  assign missing   = len_r - lv_r;
  assign lv_inc    = lv_r + LV_W'(1);
  assign new_node  = next_free_r[NODE_W-1:0];
  assign node_inc  = node_r + NODE_W'(1);

  always_comb begin
    state_nxt         = state_r;
    ins_nxt           = ins_r;
    bad_rid_nxt       = bad_rid_r;
    addr_sh_nxt       = addr_sh_r;
    len_nxt           = len_r;
    lv_nxt            = lv_r;
    rid_nxt           = rid_r;
    node_nxt          = node_r;
    at_root_nxt       = at_root_r;
    got_nxt           = got_r;
    best_nxt          = best_r;
    next_free_nxt     = next_free_r;
    root_l0_nxt       = root_l0_r;
    root_l1_nxt       = root_l1_r;
    root_has_nxt      = root_has_r;
    root_rid_nxt      = root_rid_r;
    out_valid_nxt     = 1'b0;
    out_found_nxt     = out_found_r;
    out_match_id_nxt  = out_match_id_r;
    out_pool_full_nxt = out_pool_full_r;
    ram_we            = 1'b0;
    ram_wr_addr       = node_r;
    ram_wr_data       = '0;
    ram_rd_en         = 1'b0;
    ram_rd_addr       = child;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ins_nxt     = (in_cmd == blp_pkg::CMD_INSERT);
          bad_rid_nxt = (in_cmd == blp_pkg::CMD_INSERT) &&
                        (32'(in_route_id) >= 32'(ROUTES));
          addr_sh_nxt = in_address;
          len_nxt     = blp_pkg::prefix_len(in_mask);
          lv_nxt      = '0;
          rid_nxt     = in_route_id;
          node_nxt    = '0;
          at_root_nxt = 1'b1;
          got_nxt     = 1'b0;
          best_nxt    = '0;
          state_nxt   = ST_WALK;
        end
      end

      ST_WALK: begin
        if (ins_r) begin
          if (bad_rid_r) begin
            out_valid_nxt     = 1'b1;
            out_found_nxt     = 1'b0;
            out_match_id_nxt  = '0;
            out_pool_full_nxt = 1'b0;
            state_nxt         = ST_IDLE;
          end else if (lv_r == len_r) begin
            // prefix already in the trie, attach the route here
            if (at_root_r) begin
              root_has_nxt = 1'b1;
              root_rid_nxt = rid_r;
            end else begin
              ram_we      = 1'b1;
              ram_wr_data = {cur_l0, cur_l1, 1'b1, rid_r};
            end
            out_valid_nxt     = 1'b1;
            out_found_nxt     = 1'b0;
            out_match_id_nxt  = '0;
            out_pool_full_nxt = 1'b0;
            state_nxt         = ST_IDLE;
          end else if (child == '0) begin
            if (CNT_W'(missing) > free_left) begin
              out_valid_nxt     = 1'b1;
              out_found_nxt     = 1'b0;
              out_match_id_nxt  = '0;
              out_pool_full_nxt = 1'b1;
              state_nxt         = ST_IDLE;
            end else begin
              // hook the first new node under the deepest existing one
              if (at_root_r) begin
                if (bit_now) root_l1_nxt = new_node;
                else         root_l0_nxt = new_node;
              end else begin
                ram_we      = 1'b1;
                ram_wr_data = bit_now ? {cur_l0, new_node, cur_has, cur_rid}
                                      : {new_node, cur_l1, cur_has, cur_rid};
              end
              node_nxt    = new_node;
              lv_nxt      = lv_inc;
              addr_sh_nxt = addr_sh_r << 1;
              at_root_nxt = 1'b0;
              state_nxt   = ST_FILL;
            end
          end else begin
            ram_rd_en   = 1'b1;
            node_nxt    = child;
            lv_nxt      = lv_inc;
            addr_sh_nxt = addr_sh_r << 1;
            at_root_nxt = 1'b0;
          end
        end else begin
          got_nxt  = got_now;
          best_nxt = best_now;
          if ((lv_r == LV_W'(AB)) || (child == '0)) begin
            out_valid_nxt     = 1'b1;
            out_found_nxt     = got_now;
            out_match_id_nxt  = got_now ? best_now : '0;
            out_pool_full_nxt = 1'b0;
            state_nxt         = ST_IDLE;
          end else begin
            ram_rd_en   = 1'b1;
            node_nxt    = child;
            lv_nxt      = lv_inc;
            addr_sh_nxt = addr_sh_r << 1;
            at_root_nxt = 1'b0;
          end
        end
      end

      ST_FILL: begin
        // one new node per cycle, chained down to the prefix end
        ram_we        = 1'b1;
        next_free_nxt = next_free_r + CNT_W'(1);
        if (lv_r == len_r) begin
          ram_wr_data       = {{(2*NODE_W){1'b0}}, 1'b1, rid_r};
          out_valid_nxt     = 1'b1;
          out_found_nxt     = 1'b0;
          out_match_id_nxt  = '0;
          out_pool_full_nxt = 1'b0;
          state_nxt         = ST_IDLE;
        end else begin
          ram_wr_data = bit_now ? {{NODE_W{1'b0}}, node_inc, 1'b0, {RID_W{1'b0}}}
                                : {node_inc, {NODE_W{1'b0}}, 1'b0, {RID_W{1'b0}}};
          node_nxt    = node_inc;
          lv_nxt      = lv_inc;
          addr_sh_nxt = addr_sh_r << 1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_free_r <= CNT_W'(1);
      root_l0_r   <= '0;
      root_l1_r   <= '0;
      root_has_r  <= 1'b0;
      root_rid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_free_r <= next_free_nxt;
      root_l0_r   <= root_l0_nxt;
      root_l1_r   <= root_l1_nxt;
      root_has_r  <= root_has_nxt;
      root_rid_r  <= root_rid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r           <= ins_nxt;
    bad_rid_r       <= bad_rid_nxt;
    addr_sh_r       <= addr_sh_nxt;
    len_r           <= len_nxt;
    lv_r            <= lv_nxt;
    rid_r           <= rid_nxt;
    node_r          <= node_nxt;
    at_root_r       <= at_root_nxt;
    got_r           <= got_nxt;
    best_r          <= best_nxt;
    out_found_r     <= out_found_nxt;
    out_match_id_r  <= out_match_id_nxt;
    out_pool_full_r <= out_pool_full_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_match_id  = out_match_id_r;
  assign out_pool_full = out_pool_full_r;

endmodule

// ===== rtl/core/blp_checker.sv =====
`timescale 1ns / 1ps
// port level checker for the binary trie lpm block, with its bind
module blp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_cmd,
  input logic                          out_valid,
  input logic                          out_found,
  input logic [blp_pkg::RID_W-1:0]      out_match_id,
  input logic                          out_pool_full
);

  logic cmd_r;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= in_cmd;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result beats in a row");

  a_lookup_no_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (cmd_r == blp_pkg::CMD_LOOKUP)) |-> !out_pool_full)
    else $error("lookup reported pool full");

  a_miss_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_id == '0))
    else $error("nonzero match id without a match");

endmodule

bind binary_trie_lpm blp_checker u_blp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_cmd        (in_cmd),
  .out_valid     (out_valid),
  .out_found     (out_found),
  .out_match_id  (out_match_id),
  .out_pool_full (out_pool_full)
);
